FILE: design/pon_pkg.sv
package pon_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int POINT_W = 2 * COORD_BITS;
  localparam int DATA_W  = ((POINT_W + 7) / 8) * 8;
  localparam int TERM_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * TERM_W;
  // One term per stored edge plus the closing edge.
  localparam int SUM_W   = PROD_W + $clog2(MAX_POINTS + 1);
  localparam int USER_W  = 2;
  localparam int MIN_POLY = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_CLOSE,
    S_CLOSE_WAIT,
    S_RD,
    S_LD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

endpackage

FILE: design/pon_ram.sv
module pon_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pon_mac.sv
module pon_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  pon_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [pon_pkg::COORD_BITS-1:0] x0,
  input  logic signed [pon_pkg::COORD_BITS-1:0] y0,
  input  logic signed [pon_pkg::COORD_BITS-1:0] x1,
  input  logic signed [pon_pkg::COORD_BITS-1:0] y1,
  output logic signed [pon_pkg::SUM_W-1:0]    sum,
  output logic                                done
);

  logic signed [pon_pkg::TERM_W-1:0] dy;
  logic signed [pon_pkg::TERM_W-1:0] sx;
  logic signed [pon_pkg::PROD_W-1:0] prod;
  logic                              v1;
  logic                              v2;

  // Three steps: difference and sum, product, accumulate.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dy <= pon_pkg::TERM_W'(y1) - pon_pkg::TERM_W'(y0);
      sx <= pon_pkg::TERM_W'(x1) + pon_pkg::TERM_W'(x0);
    end
    if (v1) begin
      prod <= dy * sx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
      sum  <= '0;
    end else begin
      v1   <= ctrl.start;
      v2   <= v1;
      done <= v2;
      if (ctrl.clear) begin
        sum <= '0;
      end else if (v2) begin
        sum <= sum + pon_pkg::SUM_W'(prod);
      end
    end
  end

endmodule

FILE: design/polygon_orientation_normalizer.sv
// Polygon orientation normaliser.
// Vertices arrive one word at a time on the s_ channel, x in the low half of
// s_tdata and y in the high half, with s_tlast on the final vertex. Each vertex
// that fits is written to a vertex RAM, and one shared multiply-accumulate
// unit adds the shoelace term of the edge from the previous vertex. A vertex
// with no edge term (the first one, or one dropped because the RAM already
// holds MAX_POINTS vertices) does not wait for the unit; others wait for
// the three steps of the multiply-accumulate unit. The final vertex is
// followed by the closing edge term, computed for three or more vertices.
// The stored vertices then leave on the m_ channel, in input order when the
// sum is at least zero or under three vertices are held, else reversed; each
// word is read from RAM and registered before it is offered, one at a time.
// m_tuser carries the reversal and overflow flags, the same on every word of
// a polygon, and m_tlast marks the last word. s_tready is low from the moment
// a vertex is taken until its work is finished, and during the whole burst;
// a stalled receiver simply holds the current word in place.
// Synchronous reset empties the vertex count, clears the sum and the flags,
// and leaves the block ready for a new polygon; the RAM is not cleared.
module polygon_orientation_normalizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [pon_pkg::DATA_W-1:0]  s_tdata,   // point_x, point_y
  input  logic                        s_tlast,   // final_point
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pon_pkg::DATA_W-1:0]  m_tdata,   // out_x, out_y
  output logic                        m_tlast,   // out_last
  output logic [pon_pkg::USER_W-1:0]  m_tuser    // was_reversed, overflowed
);

  pon_pkg::state_t   state;
  pon_pkg::state_t   state_next;
  pon_pkg::mac_ctrl_t mac_ctl;

  logic                              accept;
  logic                              full;
  logic                              ram_we;
  logic                              close_sel;
  logic [pon_pkg::CNT_W-1:0]         count;
  logic [pon_pkg::CNT_W-1:0]         k;
  logic [pon_pkg::CNT_W-1:0]         rd_idx;
  logic [pon_pkg::POINT_W-1:0]       first_pt;
  logic [pon_pkg::POINT_W-1:0]       prev_pt;
  logic [pon_pkg::POINT_W-1:0]       in_pt;
  logic [pon_pkg::POINT_W-1:0]       op_pt;
  logic [pon_pkg::POINT_W-1:0]       rdata;
  logic                              fin;
  logic                              dropped;
  logic                              rev;
  logic signed [pon_pkg::SUM_W-1:0]  sum;
  logic                              mac_done;
  logic [pon_pkg::POINT_W-1:0]       out_pt;
  logic                              out_last;
  logic                              out_rev;
  logic                              out_ovf;

  assign in_pt  = s_tdata[pon_pkg::POINT_W-1:0];
  assign accept = s_tvalid && s_tready;
  assign full   = (count == pon_pkg::CNT_W'(pon_pkg::MAX_POINTS));
  assign op_pt  = close_sel ? first_pt : in_pt;
  assign rd_idx = rev ? (count - pon_pkg::CNT_W'(1) - k) : k;

  pon_ram #(
    .WIDTH (pon_pkg::POINT_W),
    .DEPTH (pon_pkg::MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[pon_pkg::ADDR_W-1:0]),
    .wdata (in_pt),
    .raddr (rd_idx[pon_pkg::ADDR_W-1:0]),
    .rdata (rdata)
  );

  pon_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctl),
    .x0   (prev_pt[pon_pkg::COORD_BITS-1:0]),
    .y0   (prev_pt[pon_pkg::POINT_W-1:pon_pkg::COORD_BITS]),
    .x1   (op_pt[pon_pkg::COORD_BITS-1:0]),
    .y1   (op_pt[pon_pkg::POINT_W-1:pon_pkg::COORD_BITS]),
    .sum  (sum),
    .done (mac_done)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      pon_pkg::S_IDLE: begin
        if (accept) begin
          if (!full && count != '0) begin
            state_next = pon_pkg::S_EDGE;
          end else if (s_tlast) begin
            state_next = pon_pkg::S_CLOSE;
          end
        end
      end
      pon_pkg::S_EDGE: begin
        if (mac_done) begin
          state_next = fin ? pon_pkg::S_CLOSE : pon_pkg::S_IDLE;
        end
      end
      pon_pkg::S_CLOSE: begin
        if (count >= pon_pkg::CNT_W'(pon_pkg::MIN_POLY)) begin
          state_next = pon_pkg::S_CLOSE_WAIT;
        end else begin
          state_next = pon_pkg::S_RD;
        end
      end
      pon_pkg::S_CLOSE_WAIT: begin
        if (mac_done) begin
          state_next = pon_pkg::S_RD;
        end
      end
      pon_pkg::S_RD: state_next = pon_pkg::S_LD;
      pon_pkg::S_LD: state_next = pon_pkg::S_OUT;
      pon_pkg::S_OUT: begin
        if (m_tready) begin
          state_next = out_last ? pon_pkg::S_IDLE : pon_pkg::S_RD;
        end
      end
      default: state_next = pon_pkg::S_IDLE;
    endcase
  end

  // In the idle state s_tready is high, so s_tvalid alone marks a taken word.
  always_comb begin
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    ram_we        = 1'b0;
    close_sel     = 1'b0;
    mac_ctl.start = 1'b0;
    mac_ctl.clear = 1'b0;
    unique case (state)
      pon_pkg::S_IDLE: begin
        s_tready      = 1'b1;
        ram_we        = s_tvalid && !full;
        mac_ctl.start = s_tvalid && !full && count != '0;
      end
      pon_pkg::S_CLOSE: begin
        close_sel     = 1'b1;
        mac_ctl.start = (count >= pon_pkg::CNT_W'(pon_pkg::MIN_POLY));
      end
      pon_pkg::S_OUT: begin
        m_tvalid      = 1'b1;
        mac_ctl.clear = m_tready && out_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pon_pkg::S_IDLE;
      count   <= '0;
      k       <= '0;
      fin     <= 1'b0;
      dropped <= 1'b0;
      rev     <= 1'b0;
      first_pt <= '0;
      prev_pt  <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        pon_pkg::S_IDLE: begin
          if (accept) begin
            fin <= s_tlast;
            if (full) begin
              dropped <= 1'b1;
            end else begin
              if (count == '0) begin
                first_pt <= in_pt;
              end
              prev_pt <= in_pt;
              count   <= count + pon_pkg::CNT_W'(1);
            end
          end
        end
        pon_pkg::S_CLOSE: begin
          rev <= 1'b0;
          k   <= '0;
        end
        pon_pkg::S_CLOSE_WAIT: begin
          if (mac_done) begin
            rev <= sum[pon_pkg::SUM_W-1];
          end
        end
        pon_pkg::S_OUT: begin
          if (m_tready) begin
            if (out_last) begin
              count   <= '0;
              k       <= '0;
              fin     <= 1'b0;
              dropped <= 1'b0;
            end else begin
              k <= k + pon_pkg::CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The RAM word read in the previous cycle is captured for the output.
  always_ff @(posedge clk) begin
    if (state == pon_pkg::S_LD) begin
      out_pt   <= rdata;
      out_last <= (k == count - pon_pkg::CNT_W'(1));
      out_rev  <= rev;
      out_ovf  <= dropped;
    end
  end

  assign m_tdata = pon_pkg::DATA_W'(out_pt);
  assign m_tlast = out_last;
  assign m_tuser = {out_ovf, out_rev};

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input and output both open at once");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pon_pkg::CNT_W'(pon_pkg::MAX_POINTS))
    else $error("vertex count beyond capacity");

  a_done_expected: assert property (@(posedge clk) disable iff (rst)
    mac_done |-> (state == pon_pkg::S_EDGE || state == pon_pkg::S_CLOSE_WAIT))
    else $error("edge term finished with no one waiting for it");

  a_burst_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == pon_pkg::S_RD) |-> (count != '0 && k < count))
    else $error("read beyond the stored vertices");

  a_empty_after: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (count == '0 && sum == '0))
    else $error("polygon state not cleared after the last word");

endmodule

FILE: bench/polygon_orientation_normalizer_tb.sv
`timescale 1ns / 100ps

module polygon_orientation_normalizer_tb;

  typedef logic signed [pon_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     fin;
  } vertex_in_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     last;
    bit     reversed;
    bit     overflowed;
  } vertex_out_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [pon_pkg::DATA_W-1:0]  s_tdata = '0;    // point_x, point_y
  logic                        s_tlast = 1'b0;  // final_point
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [pon_pkg::DATA_W-1:0]  m_tdata;         // out_x, out_y
  logic                        m_tlast;         // out_last
  logic [pon_pkg::USER_W-1:0]  m_tuser;         // was_reversed, overflowed

  polygon_orientation_normalizer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  vertex_in_t  pending_vertices[$];
  vertex_out_t vertex_words_due[$];

  // Shadow of the block's polygon state.
  coord_t     held_x[pon_pkg::MAX_POINTS];
  coord_t     held_y[pon_pkg::MAX_POINTS];
  int         held_count = 0;
  coord_t     first_x = '0, first_y = '0;
  coord_t     prev_x = '0, prev_y = '0;
  longint     twice_area = 0;
  bit         dropped = 1'b0;

  int mismatches = 0;
  int words_checked = 0;
  int polygons_seen = 0;
  int reversed_polygons = 0;
  int overflow_polygons = 0;
  int vertices_sent = 0;
  int send_calm = 0, recv_calm = 0;
  int send_gap = 0, recv_hold = 0;

  function automatic longint edge_term(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    longint dy, sx;
    dy = y1;
    dy = dy - y0;
    sx = x1;
    sx = sx + x0;
    return dy * sx;
  endfunction

  // Takes one accepted vertex and, on the final one, queues the whole burst.
  function automatic void fold_vertex(coord_t x, coord_t y, bit fin);
    bit          rev;
    longint      total;
    int          src;
    vertex_out_t w;
    if (held_count < pon_pkg::MAX_POINTS) begin
      if (held_count == 0) begin
        first_x = x;
        first_y = y;
      end else begin
        twice_area += edge_term(prev_x, prev_y, x, y);
      end
      held_x[held_count] = x;
      held_y[held_count] = y;
      prev_x = x;
      prev_y = y;
      held_count++;
    end else begin
      dropped = 1'b1;
    end
    if (!fin) return;
    rev = 1'b0;
    if (held_count >= pon_pkg::MIN_POLY) begin
      total = twice_area + edge_term(prev_x, prev_y, first_x, first_y);
      rev = (total < 0);
    end
    for (int k = 0; k < held_count; k++) begin
      src = rev ? (held_count - 1 - k) : k;
      w.x = held_x[src];
      w.y = held_y[src];
      w.last = (k + 1 == held_count);
      w.reversed = rev;
      w.overflowed = dropped;
      vertex_words_due.insert(vertex_words_due.size(), w);
    end
    polygons_seen++;
    if (rev) reversed_polygons++;
    if (dropped) overflow_polygons++;
    held_count = 0;
    twice_area = 0;
    dropped = 1'b0;
  endfunction

  // Mostly short pauses, now and then a long one, and calm stretches with none.
  function automatic int pick_pause(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 59) == 0) begin
      calm = $urandom_range(20, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t pick_coord(int centre);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return coord_t'($urandom);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0: return coord_t'(-32768);
        1: return coord_t'(32767);
        2: return coord_t'(0);
        default: return coord_t'(-1);
      endcase
    end
    return coord_t'(centre + int'($urandom_range(0, 400)) - 200);
  endfunction

  task automatic add_vertex(int x, int y, bit fin);
    vertex_in_t v;
    v.x = coord_t'(x);
    v.y = coord_t'(y);
    v.fin = fin;
    pending_vertices.insert(pending_vertices.size(), v);
  endtask

  // Driver: presents queued vertices with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        fold_vertex(coord_t'(s_tdata[pon_pkg::COORD_BITS-1:0]),
                    coord_t'(s_tdata[2*pon_pkg::COORD_BITS-1:pon_pkg::COORD_BITS]),
                    s_tlast);
        vertices_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          vertex_in_t v;
          v = pending_vertices.pop_front();
          s_tdata <= pon_pkg::DATA_W'({v.y, v.x});
          s_tlast <= v.fin;
          s_tvalid <= 1'b1;
          send_gap = pick_pause(send_calm);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the output at random and checks each word taken.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        vertex_out_t w;
        coord_t      got_x, got_y;
        got_x = coord_t'(m_tdata[pon_pkg::COORD_BITS-1:0]);
        got_y = coord_t'(m_tdata[2*pon_pkg::COORD_BITS-1:pon_pkg::COORD_BITS]);
        if (vertex_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected word x=%0d y=%0d last=%0b user=%b",
                     $realtime, got_x, got_y, m_tlast, m_tuser);
        end else begin
          w = vertex_words_due.pop_front();
          words_checked++;
          if (got_x !== w.x || got_y !== w.y || m_tlast !== w.last ||
              m_tuser[0] !== w.reversed || m_tuser[1] !== w.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: word mismatch: expected x=%0d y=%0d last=%0b rev=%0b ",
                        "ovf=%0b, got x=%0d y=%0d last=%0b rev=%0b ovf=%0b"},
                       $realtime, w.x, w.y, w.last, w.reversed, w.overflowed,
                       got_x, got_y, m_tlast, m_tuser[0], m_tuser[1]);
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) recv_hold = pick_pause(recv_calm);
      end
    end
  end

  initial begin
    int random_vertices;
    int poly_index;
    int size;
    int centre_x, centre_y;
    // Directed polygons: degenerate sizes, both orientations, a zero sum and
    // the coordinate extremes.
    add_vertex(32767, -32768, 1'b1);
    add_vertex(-32768, 32767, 1'b0);
    add_vertex(0, 0, 1'b1);
    add_vertex(0, 0, 1'b0);
    add_vertex(10, 0, 1'b0);
    add_vertex(0, 10, 1'b1);
    add_vertex(0, 0, 1'b0);
    add_vertex(0, 10, 1'b0);
    add_vertex(10, 0, 1'b1);
    add_vertex(1, 1, 1'b0);
    add_vertex(2, 2, 1'b0);
    add_vertex(3, 3, 1'b1);
    add_vertex(-32768, -32768, 1'b0);
    add_vertex(32767, -32768, 1'b0);
    add_vertex(32767, 32767, 1'b0);
    add_vertex(-32768, 32767, 1'b1);
    add_vertex(-32768, 32767, 1'b0);
    add_vertex(32767, 32767, 1'b0);
    add_vertex(32767, -32768, 1'b0);
    add_vertex(-32768, -32768, 1'b1);
    add_vertex(-1, 0, 1'b0);
    add_vertex(0, -1, 1'b0);
    add_vertex(-1, -1, 1'b1);

    // Random polygons, mostly small; a few fill the store or spill over it.
    random_vertices = 0;
    poly_index = 0;
    while (random_vertices < 445) begin
      if (poly_index == 2) size = pon_pkg::MAX_POINTS;
      else if (poly_index == 5) size = pon_pkg::MAX_POINTS + 2;
      else if (poly_index == 9) size = pon_pkg::MAX_POINTS + 1;
      else if ($urandom_range(0, 29) == 0)
        size = $urandom_range(pon_pkg::MAX_POINTS - 4, pon_pkg::MAX_POINTS + 6);
      else if ($urandom_range(0, 9) == 0) size = $urandom_range(1, 2);
      else size = $urandom_range(3, 10);
      centre_x = int'($urandom_range(0, 60000)) - 30000;
      centre_y = int'($urandom_range(0, 60000)) - 30000;
      for (int i = 0; i < size; i++)
        add_vertex(int'(pick_coord(centre_x)), int'(pick_coord(centre_y)),
                   i == size - 1);
      random_vertices += size;
      poly_index++;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pending_vertices.size() == 0 && !s_tvalid);
    wait (vertex_words_due.size() == 0);
    repeat (60) @(posedge clk);

    $display("Sent %0d vertices in %0d polygons; %0d words checked.",
             vertices_sent, polygons_seen, words_checked);
    $display("%0d polygons came out reversed and %0d overran the vertex store.",
             reversed_polygons, overflow_polygons);
    if (mismatches == 0 && vertex_words_due.size() == 0) begin
      $display("polygon_orientation_normalizer_tb passed");
    end else begin
      $display("%0d mismatches, %0d words still outstanding.",
               mismatches, vertex_words_due.size());
      $display("polygon_orientation_normalizer_tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out with %0d words outstanding.", vertex_words_due.size());
    $display("polygon_orientation_normalizer_tb failed");
    $finish;
  end

endmodule

FILE: sim.f
design/pon_pkg.sv
design/pon_ram.sv
design/pon_mac.sv
design/polygon_orientation_normalizer.sv
bench/polygon_orientation_normalizer_tb.sv
